/* sv/cylsp_pkg.sv */
// ----------------------------------------------------------------------------
// cylsp_pkg
// Shared widths, types and register indexes for the cylinder support point
// block and its vector normalization pipeline.
// ----------------------------------------------------------------------------
package cylsp_pkg;

    localparam int FRAC_BITS = 16;

    localparam int CRD_W     = 32;
    localparam int AXIS_W    = 18;
    localparam int SIZE_W    = 31;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    // normalization unit
    localparam int NIN_W    = 34;
    localparam int MAG_W    = 31;
    localparam int SH_W     = $clog2(NIN_W - MAG_W + 1);
    localparam int SQ_W     = 2 * MAG_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int SQ_STEPS = SUM_W / 2;
    localparam int LEN_W    = SQ_STEPS;
    localparam int Q_W      = FRAC_BITS + 1;
    localparam int UNIT_W   = FRAC_BITS + 2;
    localparam int NUM_W    = MAG_W + FRAC_BITS + 1;
    localparam int DIV_W    = LEN_W + Q_W;
    localparam int NORM_LAT = 3 + SQ_STEPS + Q_W;

    // top level datapath
    localparam int NA_W  = UNIT_W + AXIS_W;
    localparam int DOT_W = NA_W + 2;
    localparam int D_W   = DOT_W - FRAC_BITS + 1;
    localparam int DA_W  = D_W + AXIS_W;
    localparam int P_W   = DA_W - FRAC_BITS + 2;
    localparam int MUL_W = UNIT_W + CRD_W;
    localparam int TOT_W = NIN_W + 1;

    typedef logic signed [NIN_W-1:0]  nin_t;
    typedef logic signed [UNIT_W-1:0] unit_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIUS   = 3'd0,
        REG_HEIGHT   = 3'd1,
        REG_CENTER_X = 3'd2,
        REG_CENTER_Y = 3'd3,
        REG_CENTER_Z = 3'd4,
        REG_AXIS_X   = 3'd5,
        REG_AXIS_Y   = 3'd6,
        REG_AXIS_Z   = 3'd7
    } cfg_idx_t;

endpackage

/* sv/cylinder_support_point.sv */
// ----------------------------------------------------------------------------
// cylinder_support_point
// Support point of a cylinder along a query direction, Q16.16 fixed point.
//
// Usage:
//   Input channel in_valid/in_ready carries one direction word (dir_x/y/z).
//   Output channel out_valid/out_ready carries one point word per input word.
//   Geometry registers are written over cfg_we/cfg_addr/cfg_wdata while no
//   word is in flight; a write takes effect at once, no read-back.
//   One word per cycle is sustained while the output keeps taking words.
//   A word passes the direction, across-axis and rim normalization
//   pipelines in series (52 stages each: 32 square root bit stages, 17
//   divider bit stages) plus the dot product, projection and select stages.
//   The result register is backed by a one-word skid register: the input
//   keeps being accepted while a result waits, and in_ready drops only once
//   the skid register holds a word; then the whole pipeline holds.
//   Reset clears the geometry registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module cylinder_support_point (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [cylsp_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [cylsp_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [cylsp_pkg::CRD_W-1:0]    dir_x,
    input  logic signed [cylsp_pkg::CRD_W-1:0]    dir_y,
    input  logic signed [cylsp_pkg::CRD_W-1:0]    dir_z,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [cylsp_pkg::CRD_W-1:0]    point_x,
    output logic signed [cylsp_pkg::CRD_W-1:0]    point_y,
    output logic signed [cylsp_pkg::CRD_W-1:0]    point_z
);

    localparam int FRAC     = cylsp_pkg::FRAC_BITS;
    localparam int CRD_W    = cylsp_pkg::CRD_W;
    localparam int AXIS_W   = cylsp_pkg::AXIS_W;
    localparam int SIZE_W   = cylsp_pkg::SIZE_W;
    localparam int NIN_W    = cylsp_pkg::NIN_W;
    localparam int LAT      = cylsp_pkg::NORM_LAT;
    localparam int NA_W     = cylsp_pkg::NA_W;
    localparam int DOT_W    = cylsp_pkg::DOT_W;
    localparam int D_W      = cylsp_pkg::D_W;
    localparam int DA_W     = cylsp_pkg::DA_W;
    localparam int P_W      = cylsp_pkg::P_W;
    localparam int MUL_W    = cylsp_pkg::MUL_W;
    localparam int TOT_W    = cylsp_pkg::TOT_W;

    function automatic logic signed [63:0] round_frac(input logic signed [63:0] v);
        logic [63:0] m;
        m = v[63] ? (~v + 64'd1) : v;
        m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    // configuration
    logic [SIZE_W-1:0]        radius_reg;
    logic [SIZE_W-1:0]        height_reg;
    logic signed [CRD_W-1:0]  center_reg [3];
    logic signed [AXIS_W-1:0] axis_reg   [3];
    logic [SIZE_W:0]          hp1;
    logic [SIZE_W-1:0]        half_h;

    assign hp1    = {1'b0, height_reg} + (SIZE_W+1)'(1);
    assign half_h = hp1[SIZE_W:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= '0;
            height_reg <= '0;
            center_reg <= '{default: '0};
            axis_reg   <= '{default: '0};
        end
        else if (cfg_we)
        begin
            case (cylsp_pkg::cfg_idx_t'(cfg_addr))
                cylsp_pkg::REG_RADIUS:   radius_reg    <= cfg_wdata[SIZE_W-1:0];
                cylsp_pkg::REG_HEIGHT:   height_reg    <= cfg_wdata[SIZE_W-1:0];
                cylsp_pkg::REG_CENTER_X: center_reg[0] <= cfg_wdata[CRD_W-1:0];
                cylsp_pkg::REG_CENTER_Y: center_reg[1] <= cfg_wdata[CRD_W-1:0];
                cylsp_pkg::REG_CENTER_Z: center_reg[2] <= cfg_wdata[CRD_W-1:0];
                cylsp_pkg::REG_AXIS_X:   axis_reg[0]   <= cfg_wdata[AXIS_W-1:0];
                cylsp_pkg::REG_AXIS_Y:   axis_reg[1]   <= cfg_wdata[AXIS_W-1:0];
                cylsp_pkg::REG_AXIS_Z:   axis_reg[2]   <= cfg_wdata[AXIS_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline enable: holds while the skid register is full
    logic en;
    logic skid_v_reg;

    assign en       = !skid_v_reg;
    assign in_ready = en;

    // direction normalization, zero direction becomes (1,0,0)
    logic signed [CRD_W-1:0] dir_in [3];
    cylsp_pkg::nin_t         n1_in  [3];
    cylsp_pkg::unit_t        n1_out [3];
    logic                    dir_zero;

    assign dir_in[0] = dir_x;
    assign dir_in[1] = dir_y;
    assign dir_in[2] = dir_z;
    assign dir_zero  = (dir_x == '0) && (dir_y == '0) && (dir_z == '0);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n1_in[i] = NIN_W'(dir_in[i]);
        end
        if (dir_zero)
        begin
            n1_in[0] = NIN_W'(1);
        end
    end

    cylsp_norm u_norm_dir (
        .clk   (clk),
        .en    (en),
        .v_in  (n1_in),
        .u_out (n1_out)
    );

    logic v1_reg [LAT];

    // projection across the axis
    logic                    b1_v_reg, b2_v_reg, b3_v_reg, b4_v_reg;
    cylsp_pkg::unit_t        b1_n_reg [3];
    cylsp_pkg::unit_t        b2_n_reg [3];
    cylsp_pkg::unit_t        b3_n_reg [3];
    cylsp_pkg::unit_t        b4_n_reg [3];
    logic signed [NA_W-1:0]  b1_na_reg [3];
    logic signed [D_W-1:0]   b2_d_reg;
    logic signed [DA_W-1:0]  b3_da_reg [3];
    logic signed [P_W-1:0]   b4_p_reg  [3];
    logic signed [DOT_W-1:0] na_sum;

    assign na_sum = DOT_W'(b1_na_reg[0]) + DOT_W'(b1_na_reg[1]) + DOT_W'(b1_na_reg[2]);

    cylsp_pkg::nin_t  n2_in  [3];
    cylsp_pkg::unit_t n2_out [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n2_in[i] = NIN_W'(b4_p_reg[i]);
        end
    end

    cylsp_norm u_norm_across (
        .clk   (clk),
        .en    (en),
        .v_in  (n2_in),
        .u_out (n2_out)
    );

    logic             v2_reg [LAT];
    cylsp_pkg::unit_t n2_reg [LAT][3];

    // rim candidates
    logic                    c1_v_reg, c2_v_reg;
    cylsp_pkg::unit_t        c1_n_reg  [3];
    cylsp_pkg::unit_t        c2_n_reg  [3];
    logic signed [MUL_W-1:0] c1_rp_reg [3];
    logic signed [MUL_W-1:0] c1_ah_reg [3];
    cylsp_pkg::nin_t         c2_o1_reg [3];
    cylsp_pkg::nin_t         c2_o2_reg [3];
    cylsp_pkg::nin_t         c2_o1_next [3];
    cylsp_pkg::nin_t         c2_o2_next [3];

    always_comb
    begin
        logic signed [63:0] sh;
        logic signed [63:0] rim;
        for (int i = 0; i < 3; i++)
        begin
            sh  = round_frac(64'(c1_ah_reg[i]));
            rim = round_frac(64'(c1_rp_reg[i]));
            c2_o1_next[i] = NIN_W'(rim + sh);
            c2_o2_next[i] = NIN_W'(rim - sh);
        end
    end

    cylsp_pkg::unit_t u1_out [3];
    cylsp_pkg::unit_t u2_out [3];

    cylsp_norm u_norm_top (
        .clk   (clk),
        .en    (en),
        .v_in  (c2_o1_reg),
        .u_out (u1_out)
    );

    cylsp_norm u_norm_bot (
        .clk   (clk),
        .en    (en),
        .v_in  (c2_o2_reg),
        .u_out (u2_out)
    );

    logic             v3_reg  [LAT];
    cylsp_pkg::unit_t n3_reg  [LAT][3];
    cylsp_pkg::nin_t  o1_3reg [LAT][3];
    cylsp_pkg::nin_t  o2_3reg [LAT][3];

    // choice and final point
    logic                   d1_v_reg, d2_v_reg;
    logic signed [NA_W-1:0] d1_p1_reg [3];
    logic signed [NA_W-1:0] d1_p2_reg [3];
    cylsp_pkg::nin_t        d1_o1_reg [3];
    cylsp_pkg::nin_t        d1_o2_reg [3];
    logic signed [CRD_W-1:0] d2_pt_reg  [3];
    logic signed [CRD_W-1:0] d2_pt_next [3];

    always_comb
    begin
        logic signed [DOT_W-1:0] dot1;
        logic signed [DOT_W-1:0] dot2;
        logic signed [TOT_W-1:0] tot;
        logic                    first;
        dot1  = DOT_W'(d1_p1_reg[0]) + DOT_W'(d1_p1_reg[1]) + DOT_W'(d1_p1_reg[2]);
        dot2  = DOT_W'(d1_p2_reg[0]) + DOT_W'(d1_p2_reg[1]) + DOT_W'(d1_p2_reg[2]);
        first = dot1 > dot2;
        for (int i = 0; i < 3; i++)
        begin
            tot = TOT_W'(center_reg[i]) + TOT_W'(first ? d1_o1_reg[i] : d1_o2_reg[i]);
            if (tot[TOT_W-1:CRD_W-1] == '0 || tot[TOT_W-1:CRD_W-1] == '1)
            begin
                d2_pt_next[i] = tot[CRD_W-1:0];
            end
            else if (tot[TOT_W-1])
            begin
                d2_pt_next[i] = {1'b1, {(CRD_W-1){1'b0}}};
            end
            else
            begin
                d2_pt_next[i] = {1'b0, {(CRD_W-1){1'b1}}};
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= '{default: 1'b0};
            v2_reg   <= '{default: 1'b0};
            v3_reg   <= '{default: 1'b0};
            b1_v_reg <= 1'b0;
            b2_v_reg <= 1'b0;
            b3_v_reg <= 1'b0;
            b4_v_reg <= 1'b0;
            c1_v_reg <= 1'b0;
            c2_v_reg <= 1'b0;
            d1_v_reg <= 1'b0;
            d2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg[0] <= in_valid;
            v2_reg[0] <= b4_v_reg;
            v3_reg[0] <= c2_v_reg;
            for (int k = 1; k < LAT; k++)
            begin
                v1_reg[k] <= v1_reg[k-1];
                v2_reg[k] <= v2_reg[k-1];
                v3_reg[k] <= v3_reg[k-1];
            end
            b1_v_reg <= v1_reg[LAT-1];
            b2_v_reg <= b1_v_reg;
            b3_v_reg <= b2_v_reg;
            b4_v_reg <= b3_v_reg;
            c1_v_reg <= v2_reg[LAT-1];
            c2_v_reg <= c1_v_reg;
            d1_v_reg <= v3_reg[LAT-1];
            d2_v_reg <= d1_v_reg;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                b1_na_reg[i] <= NA_W'(n1_out[i]) * NA_W'(axis_reg[i]);
                b3_da_reg[i] <= DA_W'(b2_d_reg) * DA_W'(axis_reg[i]);
                b4_p_reg[i]  <= P_W'(b3_n_reg[i])
                              - P_W'(round_frac(64'(b3_da_reg[i])));
                c1_rp_reg[i] <= MUL_W'(n2_out[i]) * MUL_W'($signed({1'b0, radius_reg}));
                c1_ah_reg[i] <= MUL_W'(axis_reg[i]) * MUL_W'($signed({1'b0, half_h}));
                d1_p1_reg[i] <= NA_W'(n3_reg[LAT-1][i]) * NA_W'(u1_out[i]);
                d1_p2_reg[i] <= NA_W'(n3_reg[LAT-1][i]) * NA_W'(u2_out[i]);
            end
            b1_n_reg <= n1_out;
            b2_d_reg <= D_W'(round_frac(64'(na_sum)));
            b2_n_reg <= b1_n_reg;
            b3_n_reg <= b2_n_reg;
            b4_n_reg <= b3_n_reg;

            n2_reg[0] <= b4_n_reg;
            for (int k = 1; k < LAT; k++)
            begin
                n2_reg[k] <= n2_reg[k-1];
            end

            c1_n_reg  <= n2_reg[LAT-1];
            c2_n_reg  <= c1_n_reg;
            c2_o1_reg <= c2_o1_next;
            c2_o2_reg <= c2_o2_next;

            n3_reg[0]  <= c2_n_reg;
            o1_3reg[0] <= c2_o1_reg;
            o2_3reg[0] <= c2_o2_reg;
            for (int k = 1; k < LAT; k++)
            begin
                n3_reg[k]  <= n3_reg[k-1];
                o1_3reg[k] <= o1_3reg[k-1];
                o2_3reg[k] <= o2_3reg[k-1];
            end

            d1_o1_reg <= o1_3reg[LAT-1];
            d1_o2_reg <= o2_3reg[LAT-1];
            d2_pt_reg <= d2_pt_next;
        end
    end

    // output register with skid word
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    skid_v_next;
    logic signed [CRD_W-1:0] out_pt_reg   [3];
    logic signed [CRD_W-1:0] out_pt_next  [3];
    logic signed [CRD_W-1:0] skid_pt_reg  [3];
    logic signed [CRD_W-1:0] skid_pt_next [3];
    logic                    pop;
    logic                    arrive;

    assign pop    = out_valid_reg && out_ready;
    assign arrive = en && d2_v_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        skid_v_next    = skid_v_reg;
        out_pt_next    = out_pt_reg;
        skid_pt_next   = skid_pt_reg;
        if (skid_v_reg)
        begin
            if (pop)
            begin
                out_valid_next = 1'b1;
                out_pt_next    = skid_pt_reg;
                skid_v_next    = 1'b0;
            end
        end
        else if (!out_valid_reg || pop)
        begin
            out_valid_next = arrive;
            out_pt_next    = d2_pt_reg;
        end
        else if (arrive)
        begin
            skid_v_next  = 1'b1;
            skid_pt_next = d2_pt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_v_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_v_reg    <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_pt_reg  <= out_pt_next;
        skid_pt_reg <= skid_pt_next;
    end

    assign out_valid = out_valid_reg;
    assign point_x   = out_pt_reg[0];
    assign point_y   = out_pt_reg[1];
    assign point_z   = out_pt_reg[2];

    // checks
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_valid_reg)
        else $error("skid word held without an output word");

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_v_reg && !out_ready) |=> skid_v_reg)
        else $error("skid word lost while output stalled");

    a_last_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (d2_v_reg && !en) |=> d2_v_reg)
        else $error("last stage word lost during stall");

    a_out_drop_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid_reg) |-> $past(out_ready))
        else $error("output word dropped without being taken");

endmodule

/* sv/cylsp_norm.sv */
// ----------------------------------------------------------------------------
// cylsp_norm
// Pipelined 3-vector normalization: range shift, squares, sum, one integer
// square root bit per stage, one quotient bit per stage per component.
// ----------------------------------------------------------------------------
module cylsp_norm (
    input  logic             clk,
    input  logic             en,
    input  cylsp_pkg::nin_t  v_in  [3],
    output cylsp_pkg::unit_t u_out [3]
);

    localparam int NIN_W    = cylsp_pkg::NIN_W;
    localparam int MAG_W    = cylsp_pkg::MAG_W;
    localparam int SH_W     = cylsp_pkg::SH_W;
    localparam int SQ_W     = cylsp_pkg::SQ_W;
    localparam int SUM_W    = cylsp_pkg::SUM_W;
    localparam int SQ_STEPS = cylsp_pkg::SQ_STEPS;
    localparam int LEN_W    = cylsp_pkg::LEN_W;
    localparam int Q_W      = cylsp_pkg::Q_W;
    localparam int UNIT_W   = cylsp_pkg::UNIT_W;
    localparam int NUM_W    = cylsp_pkg::NUM_W;
    localparam int DIV_W    = cylsp_pkg::DIV_W;
    localparam int FRAC     = cylsp_pkg::FRAC_BITS;

    // stage 0: magnitudes, common shift
    logic [NIN_W-1:0] mag_full [3];
    logic [NIN_W-1:0] mag_or;
    logic [SH_W-1:0]  shamt;
    logic [MAG_W-1:0] m0_next  [3];
    logic [MAG_W-1:0] m0_reg   [3];
    logic             neg0_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_full[i] = v_in[i][NIN_W-1] ? NIN_W'(-v_in[i]) : NIN_W'(v_in[i]);
        end
        mag_or = mag_full[0] | mag_full[1] | mag_full[2];
        shamt  = '0;
        for (int b = MAG_W; b < NIN_W; b++)
        begin
            if (mag_or[b])
            begin
                shamt = SH_W'(b - MAG_W + 1);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            m0_next[i] = MAG_W'(mag_full[i] >> shamt);
        end
    end

    // stage 1: squares
    logic [SQ_W-1:0]  sq1_reg  [3];
    logic [MAG_W-1:0] m1_reg   [3];
    logic             neg1_reg [3];

    // square root pipeline, entry 0 holds the sum of squares
    logic [SUM_W-1:0] rx_reg   [SQ_STEPS+1];
    logic [SUM_W-1:0] rr_reg   [SQ_STEPS+1];
    logic [MAG_W-1:0] rm_reg   [SQ_STEPS+1][3];
    logic             rneg_reg [SQ_STEPS+1][3];
    logic [SUM_W-1:0] rx_next  [SQ_STEPS];
    logic [SUM_W-1:0] rr_next  [SQ_STEPS];

    always_comb
    begin
        logic [SUM_W:0] bitv;
        logic [SUM_W:0] trial;
        for (int k = 0; k < SQ_STEPS; k++)
        begin
            bitv  = (SUM_W+1)'(1) << (SUM_W - 2 - 2 * k);
            trial = {1'b0, rr_reg[k]} + bitv;
            if ({1'b0, rx_reg[k]} >= trial)
            begin
                rx_next[k] = rx_reg[k] - trial[SUM_W-1:0];
                rr_next[k] = (rr_reg[k] >> 1) + bitv[SUM_W-1:0];
            end
            else
            begin
                rx_next[k] = rx_reg[k];
                rr_next[k] = rr_reg[k] >> 1;
            end
        end
    end

    // divider pipeline, one quotient bit per stage
    logic [NUM_W-1:0] di_rem [Q_W][3];
    logic [Q_W-1:0]   di_q   [Q_W][3];
    logic [LEN_W-1:0] di_len [Q_W];
    logic             di_neg [Q_W][3];
    logic [NUM_W-1:0] dv_rem_next [Q_W][3];
    logic [Q_W-1:0]   dv_q_next   [Q_W][3];
    logic [NUM_W-1:0] dv_rem_reg  [Q_W][3];
    logic [Q_W-1:0]   dv_q_reg    [Q_W][3];
    logic [LEN_W-1:0] dv_len_reg  [Q_W];
    logic             dv_neg_reg  [Q_W][3];

    always_comb
    begin
        logic [LEN_W-1:0] len0;
        logic [DIV_W-1:0] dtrial;
        len0 = LEN_W'(rr_reg[SQ_STEPS]);
        for (int i = 0; i < 3; i++)
        begin
            di_rem[0][i] = NUM_W'({rm_reg[SQ_STEPS][i], {FRAC{1'b0}}})
                         + NUM_W'(len0 >> 1);
            di_q[0][i]   = '0;
            di_neg[0][i] = rneg_reg[SQ_STEPS][i];
        end
        di_len[0] = len0;
        for (int j = 1; j < Q_W; j++)
        begin
            di_rem[j] = dv_rem_reg[j-1];
            di_q[j]   = dv_q_reg[j-1];
            di_len[j] = dv_len_reg[j-1];
            di_neg[j] = dv_neg_reg[j-1];
        end
        for (int j = 0; j < Q_W; j++)
        begin
            dtrial = DIV_W'(di_len[j]) << (Q_W - 1 - j);
            for (int i = 0; i < 3; i++)
            begin
                if (DIV_W'(di_rem[j][i]) >= dtrial)
                begin
                    dv_rem_next[j][i] = di_rem[j][i] - NUM_W'(dtrial);
                    dv_q_next[j][i]   = di_q[j][i] | (Q_W'(1) << (Q_W - 1 - j));
                end
                else
                begin
                    dv_rem_next[j][i] = di_rem[j][i];
                    dv_q_next[j][i]   = di_q[j][i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m0_reg   <= m0_next;
            for (int i = 0; i < 3; i++)
            begin
                neg0_reg[i] <= v_in[i][NIN_W-1];
                sq1_reg[i]  <= SQ_W'(m0_reg[i]) * SQ_W'(m0_reg[i]);
            end
            m1_reg   <= m0_reg;
            neg1_reg <= neg0_reg;

            rx_reg[0]   <= SUM_W'(sq1_reg[0]) + SUM_W'(sq1_reg[1]) + SUM_W'(sq1_reg[2]);
            rr_reg[0]   <= '0;
            rm_reg[0]   <= m1_reg;
            rneg_reg[0] <= neg1_reg;
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                rx_reg[k+1]   <= rx_next[k];
                rr_reg[k+1]   <= rr_next[k];
                rm_reg[k+1]   <= rm_reg[k];
                rneg_reg[k+1] <= rneg_reg[k];
            end

            for (int j = 0; j < Q_W; j++)
            begin
                dv_rem_reg[j] <= dv_rem_next[j];
                dv_q_reg[j]   <= dv_q_next[j];
                dv_len_reg[j] <= di_len[j];
                dv_neg_reg[j] <= di_neg[j];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dv_len_reg[Q_W-1] == '0)
            begin
                u_out[i] = '0;
            end
            else if (dv_neg_reg[Q_W-1][i])
            begin
                u_out[i] = -UNIT_W'(dv_q_reg[Q_W-1][i]);
            end
            else
            begin
                u_out[i] = UNIT_W'(dv_q_reg[Q_W-1][i]);
            end
        end
    end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for cylinder_support_point. Directed geometry phases
// (reset state, extreme registers, tilted axes) and random direction words
// stream through valid/ready channels with random stalls; every point word
// is compared against a bit-exact fixed-point support predictor.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LATENCY  = 165;
    localparam int WDOG_MAX = 20000;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vec_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               chk;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic signed [31:0] ez;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [cylsp_pkg::CFG_IDX_W-1:0] cfg_addr;
    logic [cylsp_pkg::CFG_W-1:0] cfg_wdata;
    logic in_valid;
    logic in_ready;
    logic signed [31:0] dir_x, dir_y, dir_z;
    logic out_valid;
    logic out_ready;
    logic signed [31:0] point_x, point_y, point_z;

    // geometry shadow
    longint g_radius, g_height, g_cx, g_cy, g_cz, g_ax, g_ay, g_az;

    vec_t expected_points[$];
    int   err_count;
    int   wdog;
    bit   out_calm;
    bit   in_calm;

    cylinder_support_point DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .point_x(point_x), .point_y(point_y), .point_z(point_z)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned absval(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint rnd_q(longint v);
        longint unsigned m;
        m = (absval(v) + (64'd1 << (cylsp_pkg::FRAC_BITS - 1))) >> cylsp_pkg::FRAC_BITS;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    task automatic unit_vec(input longint v[3], output longint o[3]);
        longint unsigned m[3];
        longint unsigned len, q;
        for (int i = 0; i < 3; i++)
            m[i] = absval(v[i]);
        while (m[0] >= 64'h8000_0000 || m[1] >= 64'h8000_0000 || m[2] >= 64'h8000_0000)
        begin
            m[0] >>= 1; m[1] >>= 1; m[2] >>= 1;
        end
        len = int_sqrt(m[0]*m[0] + m[1]*m[1] + m[2]*m[2]);
        for (int i = 0; i < 3; i++)
        begin
            if (len == 0)
                o[i] = 0;
            else
            begin
                q = ((m[i] << cylsp_pkg::FRAC_BITS) + (len >> 1)) / len;
                o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
            end
        end
    endtask

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sh7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        if (v < -64'sh8000_0000)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    task automatic support_point(input vec_t dv, output vec_t pt);
        longint dir[3], n[3], a[3], c[3], p[3], pn[3], o1[3], o2[3], u1[3], u2[3];
        longint d, h, sh, rim;
        bit use_top;
        dir[0] = dv.x; dir[1] = dv.y; dir[2] = dv.z;
        a[0] = g_ax; a[1] = g_ay; a[2] = g_az;
        c[0] = g_cx; c[1] = g_cy; c[2] = g_cz;
        h = (g_height + 1) >>> 1;
        if (dir[0] == 0 && dir[1] == 0 && dir[2] == 0)
        begin
            n[0] = 64'sd1 << cylsp_pkg::FRAC_BITS; n[1] = 0; n[2] = 0;
        end
        else
            unit_vec(dir, n);
        d = rnd_q(n[0]*a[0] + n[1]*a[1] + n[2]*a[2]);
        for (int i = 0; i < 3; i++)
            p[i] = n[i] - rnd_q(d * a[i]);
        if (p[0] != 0 || p[1] != 0 || p[2] != 0)
        begin
            unit_vec(p, pn);
            p = pn;
        end
        for (int i = 0; i < 3; i++)
        begin
            sh = rnd_q(a[i] * h);
            rim = rnd_q(p[i] * g_radius);
            o1[i] = sh + rim;
            o2[i] = rim - sh;
        end
        unit_vec(o1, u1);
        unit_vec(o2, u2);
        use_top = (n[0]*u1[0] + n[1]*u1[1] + n[2]*u1[2])
                > (n[0]*u2[0] + n[1]*u2[1] + n[2]*u2[2]);
        pt.x = clamp32(c[0] + (use_top ? o1[0] : o2[0]));
        pt.y = clamp32(c[1] + (use_top ? o1[1] : o2[1]));
        pt.z = clamp32(c[2] + (use_top ? o1[2] : o2[2]));
    endtask

    task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                   input logic signed [31:0] exp_v);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_v, $realtime);
        err_count++;
    endtask

    task automatic write_reg(input cylsp_pkg::cfg_idx_t idx, input longint val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val[31:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            cylsp_pkg::REG_RADIUS:   g_radius = val & 64'h7FFF_FFFF;
            cylsp_pkg::REG_HEIGHT:   g_height = val & 64'h7FFF_FFFF;
            cylsp_pkg::REG_CENTER_X: g_cx = longint'(signed'(val[31:0]));
            cylsp_pkg::REG_CENTER_Y: g_cy = longint'(signed'(val[31:0]));
            cylsp_pkg::REG_CENTER_Z: g_cz = longint'(signed'(val[31:0]));
            cylsp_pkg::REG_AXIS_X:   g_ax = longint'(signed'(val[17:0]));
            cylsp_pkg::REG_AXIS_Y:   g_ay = longint'(signed'(val[17:0]));
            default:                 g_az = longint'(signed'(val[17:0]));
        endcase
    endtask

    task automatic set_geometry(input longint r, input longint hh, input longint cx,
                                input longint cy, input longint cz, input longint ax,
                                input longint ay, input longint az);
        in_valid <= 1'b0;
        wait (expected_points.size() == 0);
        repeat (LATENCY + 10) @(negedge clk);
        write_reg(cylsp_pkg::REG_RADIUS, r);
        write_reg(cylsp_pkg::REG_HEIGHT, hh);
        write_reg(cylsp_pkg::REG_CENTER_X, cx);
        write_reg(cylsp_pkg::REG_CENTER_Y, cy);
        write_reg(cylsp_pkg::REG_CENTER_Z, cz);
        write_reg(cylsp_pkg::REG_AXIS_X, ax);
        write_reg(cylsp_pkg::REG_AXIS_Y, ay);
        write_reg(cylsp_pkg::REG_AXIS_Z, az);
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            1: return 32'(int'($urandom_range(0, 20)) - 10);
            2: return 0;
            default: return $urandom;
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so the next word can follow with no gap
    task automatic send_dir(input vec_t dv);
        vec_t pt;
        while (!in_calm && $urandom_range(0, 99) < 18)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        dir_x <= dv.x;
        dir_y <= dv.y;
        dir_z <= dv.z;
        support_point(dv, pt);
        expected_points.push_back(pt);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic random_words(input int count);
        vec_t dv;
        for (int k = 0; k < count; k++)
        begin
            dv.x = rand_coord();
            dv.y = rand_coord();
            dv.z = rand_coord();
            send_dir(dv);
        end
    endtask

    // out channel: check and random stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_points.size() == 0)
            begin
                $display("unexpected point word at %0t", $realtime);
                err_count++;
            end
            else
            begin
                vec_t e;
                e = expected_points.pop_front();
                if (point_x !== e.x) report_mismatch("point_x", point_x, e.x);
                if (point_y !== e.y) report_mismatch("point_y", point_y, e.y);
                if (point_z !== e.z) report_mismatch("point_z", point_z, e.z);
            end
        end
    end

    always @(negedge clk)
        out_ready <= out_calm ? 1'b1 : ($urandom_range(0, 99) >= 18);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            wdog <= 0;
        else
            wdog <= wdog + 1;
    end

    initial
    begin
        wait (wdog >= WDOG_MAX);
        $display("cylinder_support_point regression: fail");
        $finish;
    end

    dir_row_t dir_table[10] = '{
        '{32'sd0, 32'sd0, 32'sd0, 1'b1, 32'sd0, 32'sd0, 32'sd0},
        '{32'sh7FFF_FFFF, 32'sd0, 32'sd0, 1'b1, 32'sd0, 32'sd0, 32'sd0},
        '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1, 32'sd0, 32'sd0, 32'sd0},
        '{32'sd1, 32'sd0, 32'sd0, 1'b0, 0, 0, 0},
        '{32'sd0, -32'sd1, 32'sd0, 1'b0, 0, 0, 0},
        '{32'sd0, 32'sd0, 32'sh7FFF_FFFF, 1'b0, 0, 0, 0},
        '{32'sd65536, 32'sd65536, 32'sd0, 1'b0, 0, 0, 0},
        '{-32'sd3, 32'sd4, -32'sd5, 1'b0, 0, 0, 0},
        '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 0, 0, 0},
        '{32'sd0, 32'sd0, 32'sd1, 1'b0, 0, 0, 0}
    };

    initial
    begin
        vec_t dv;
        vec_t pt;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        dir_x = 0; dir_y = 0; dir_z = 0;
        out_ready = 1'b1;
        out_calm = 1'b0;
        in_calm = 1'b0;
        err_count = 0;
        wdog = 0;
        g_radius = 0; g_height = 0; g_cx = 0; g_cy = 0; g_cz = 0;
        g_ax = 0; g_ay = 0; g_az = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset geometry: every point is the zero origin
        for (int k = 0; k < 3; k++)
        begin
            dv.x = dir_table[k].x; dv.y = dir_table[k].y; dv.z = dir_table[k].z;
            support_point(dv, pt);
            if (dir_table[k].chk && (pt.x !== dir_table[k].ex || pt.y !== dir_table[k].ey
                                     || pt.z !== dir_table[k].ez))
            begin
                $display("predictor disagrees with table row %0d", k);
                err_count++;
            end
            send_dir(dv);
        end

        // unit cylinder along z, then saturating extremes, then a tilted axis
        set_geometry(65536, 131072, 0, 0, 0, 0, 0, 65536);
        foreach (dir_table[k])
        begin
            dv.x = dir_table[k].x; dv.y = dir_table[k].y; dv.z = dir_table[k].z;
            send_dir(dv);
        end
        set_geometry(64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'h7FFF_FFFF, -64'sh8000_0000,
                     64'h7FFF_FFFF, -65536, 65536, -65536);
        foreach (dir_table[k])
        begin
            dv.x = dir_table[k].x; dv.y = dir_table[k].y; dv.z = dir_table[k].z;
            send_dir(dv);
        end
        set_geometry(3 << 16, 5 << 16, -100000, 200000, 7, 46341, 0, -46341);
        random_words(200);

        in_calm = 1'b1;
        out_calm = 1'b1;
        random_words(150);
        in_calm = 1'b0;
        out_calm = 1'b0;

        set_geometry($urandom & 32'h7FFF_FFFF, $urandom & 32'h7FFF_FFFF,
                     longint'(signed'(32'($urandom))), longint'(signed'(32'($urandom))),
                     longint'(signed'(32'($urandom))), int'($urandom_range(0, 131072)) - 65536,
                     int'($urandom_range(0, 131072)) - 65536,
                     int'($urandom_range(0, 131072)) - 65536);
        random_words(200);
        set_geometry(0, 0, 0, 0, 0, 0, 37837, 37837);
        random_words(150);

        in_valid <= 1'b0;
        wait (expected_points.size() == 0);
        repeat (LATENCY + 20) @(negedge clk);
        if (err_count == 0)
            $display("cylinder_support_point regression: pass");
        else
            $display("cylinder_support_point regression: fail");
        $finish;
    end
endmodule
